// ===== src/tgct_pkg.sv =====
// tgct_pkg: types, codes and constants for the two-phase gather completion tracker
// shared by the tracker top level, the expected-bytes unit and the port checker
`timescale 1ns / 1ps
`default_nettype none

package tgct_pkg;

   localparam int MAX_RANKS_DEF  = 256;
   localparam int COUNT_BITS_DEF = 48;

   localparam int CSR_ADDR_BITS = 4;
   localparam int CSR_DATA_BITS = 32;

   // chunk (32) times ranks per node (5), then times node count (9)
   localparam int PROD1_BITS = 37;
   localparam int PROD_BITS  = 46;

   localparam logic [1:0] REG_RANKS_PER_NODE = 2'd0;
   localparam logic [1:0] REG_NODE_COUNT     = 2'd1;
   localparam logic [1:0] REG_RANK_COUNT     = 2'd2;
   localparam logic [1:0] REG_CHUNK_BYTES    = 2'd3;

   localparam logic [4:0]  RANKS_PER_NODE_RST = 5'd8;
   localparam logic [8:0]  NODE_COUNT_RST     = 9'd1;
   localparam logic [8:0]  RANK_COUNT_RST     = 9'd1;
   localparam logic [31:0] CHUNK_BYTES_RST    = 32'd0;

   typedef enum logic [1:0] {
      CMD_PACKET      = 2'd0,
      CMD_START_LOCAL = 2'd1,
      CMD_START_INTER = 2'd2
   } cmd_type;

   typedef enum logic [1:0] {
      PH_IDLE  = 2'd0,
      PH_LOCAL = 2'd1,
      PH_INTER = 2'd2,
      PH_DONE  = 2'd3
   } phase_type;

   typedef struct packed {
      cmd_type     cmd;
      logic [7:0]  dest_rank;
      logic [31:0] effective_size;
      logic [31:0] payload_size;
   } req_type;

   typedef struct packed {
      phase_type  phase_now;
      logic       rank_became_done;
      logic       phase_finished;
      logic [8:0] ranks_done;
      logic       bad_rank;
   } rsp_type;

   typedef struct packed {
      logic [4:0]  ranks_per_node;
      logic [8:0]  node_count;
      logic [8:0]  rank_count;
      logic [31:0] chunk_bytes;
   } cfg_type;

endpackage

`default_nettype wire

// ===== src/two_phase_gather_completion_tracker.sv =====
// two_phase_gather_completion_tracker: per-rank byte counters in one memory
// depends on tgct_pkg and tgct_expect
//
// usage
//   req channel: valid/ready beats of {cmd, dest_rank, effective_size, payload_size}
//   rsp channel: one valid/ready beat per request with phase, done flags and done count
//   csr port: apb-style, four registers of 5, 9, 9 and 32 bits at byte offsets 0, 4, 8 and 12
// timing
//   a packet beat is a memory read, then add, compare and write back
//   a start command ends in a clearing pass over all MAX_RANKS entries,
//   one memory entry per cycle, during which req_ready stays low
//   after a csr write or a phase change req_ready holds low while the
//   expected-byte multiplier pipeline settles
//   one request is in flight at a time; the next is taken once its result is
//   in the output register, so a waiting result does not block the next beat
// reset
//   synchronous; registers return to defaults, phase goes idle and the
//   clearing pass runs over all MAX_RANKS entries before the first request is taken
// stall
//   if rsp_ready is low the result holds; a finished request waits in the
//   update step until the output register frees
`timescale 1ns / 1ps
`default_nettype none

module two_phase_gather_completion_tracker #(
   parameter int MAX_RANKS  = tgct_pkg::MAX_RANKS_DEF,
   parameter int COUNT_BITS = tgct_pkg::COUNT_BITS_DEF
) (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   input  wire logic                                 req_valid,
   output logic                                      req_ready,
   input  wire tgct_pkg::req_type                    req_data,
   output logic                                      rsp_valid,
   input  wire logic                                 rsp_ready,
   output tgct_pkg::rsp_type                         rsp_data,
   input  wire logic                                 psel,
   input  wire logic                                 penable,
   input  wire logic                                 pwrite,
   input  wire logic [tgct_pkg::CSR_ADDR_BITS-1:0]   paddr,
   input  wire logic [tgct_pkg::CSR_DATA_BITS-1:0]   pwdata,
   output logic [tgct_pkg::CSR_DATA_BITS-1:0]        prdata,
   output logic                                      pready
);
   import tgct_pkg::*;

   localparam int AW = $clog2(MAX_RANKS);
   localparam int WW = COUNT_BITS + 1;
   localparam logic [1:0] SettleCycles = 2'd3;

   typedef enum logic [1:0] {
      S_CLEAR,
      S_READY,
      S_UPDATE
   } state_type;

   logic [WW-1:0] mem [MAX_RANKS];

   state_type             state_ff, state_in;
   phase_type             phase_ff, phase_in;
   logic [8:0]            total_ff, total_in;
   logic [1:0]            settle_ff, settle_in;
   logic [AW-1:0]         clr_addr_ff, clr_addr_in;
   cfg_type               cfg_ff, cfg_in;
   req_type               item_ff, item_in;
   rsp_type               rsp_data_ff, rsp_data_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [WW-1:0]         rd_data_ff;

   logic                  cfg_write;
   logic                  wr_en;
   logic [AW-1:0]         wr_addr;
   logic [WW-1:0]         wr_data;
   logic                  rd_en;
   logic [AW-1:0]         item_addr;
   logic [COUNT_BITS-1:0] expected;
   logic [31:0]           size;
   logic [WW-1:0]         sum;
   logic [COUNT_BITS-1:0] new_cnt;
   logic                  reach;
   logic                  was_done;
   logic                  in_range;
   logic [8:0]            active;
   logic [8:0]            total_inc;
   logic                  out_free;
   logic                  became;
   logic                  finished;
   logic                  bad;

   tgct_expect #(
      .COUNT_BITS(COUNT_BITS)
   ) u_expect (
      .clock   (clock),
      .cfg     (cfg_ff),
      .phase   (phase_ff),
      .expected(expected)
   );

   // csr port
   assign cfg_write = psel && penable && pwrite;
   assign pready    = 1'b1;

   always_comb begin
      cfg_in = cfg_ff;
      if (cfg_write) begin
         unique case (paddr[3:2])
            REG_RANKS_PER_NODE: cfg_in.ranks_per_node = pwdata[4:0];
            REG_NODE_COUNT:     cfg_in.node_count     = pwdata[8:0];
            REG_RANK_COUNT:     cfg_in.rank_count     = pwdata[8:0];
            REG_CHUNK_BYTES:    cfg_in.chunk_bytes    = pwdata;
            default:            cfg_in = cfg_ff;
         endcase
      end
   end

   always_comb begin
      unique case (paddr[3:2])
         REG_RANKS_PER_NODE: prdata = 32'(cfg_ff.ranks_per_node);
         REG_NODE_COUNT:     prdata = 32'(cfg_ff.node_count);
         REG_RANK_COUNT:     prdata = 32'(cfg_ff.rank_count);
         REG_CHUNK_BYTES:    prdata = cfg_ff.chunk_bytes;
         default:            prdata = '0;
      endcase
   end

   // counter update datapath
   assign item_addr = AW'(item_ff.dest_rank);
   assign size      = (item_ff.effective_size != 32'd0) ? item_ff.effective_size
                                                         : item_ff.payload_size;
   assign sum       = {1'b0, rd_data_ff[COUNT_BITS-1:0]} + WW'(size);
   assign new_cnt   = sum[COUNT_BITS] ? {COUNT_BITS{1'b1}} : sum[COUNT_BITS-1:0];
   assign reach     = new_cnt >= expected;
   assign was_done  = rd_data_ff[COUNT_BITS];
   assign active    = (32'(cfg_ff.rank_count) < MAX_RANKS) ? cfg_ff.rank_count
                                                           : 9'(MAX_RANKS);
   assign in_range  = (32'(item_ff.dest_rank) < MAX_RANKS)
                      && ({1'b0, item_ff.dest_rank} < cfg_ff.rank_count);
   assign total_inc = total_ff + 9'd1;
   assign out_free  = !rsp_valid_ff || rsp_ready;

   assign req_ready = (state_ff == S_READY) && (settle_ff == 2'd0);

   always_comb begin
      state_in     = state_ff;
      phase_in     = phase_ff;
      total_in     = total_ff;
      clr_addr_in  = clr_addr_ff;
      item_in      = item_ff;
      rsp_data_in  = rsp_data_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      wr_en        = 1'b0;
      wr_addr      = clr_addr_ff;
      wr_data      = '0;
      rd_en        = 1'b0;
      became       = 1'b0;
      finished     = 1'b0;
      bad          = 1'b0;
      unique case (state_ff)
         S_CLEAR: begin
            wr_en       = 1'b1;
            clr_addr_in = clr_addr_ff + AW'(1);
            if (clr_addr_ff == AW'(MAX_RANKS - 1)) begin
               state_in = S_READY;
            end
         end
         S_READY: begin
            if (req_valid && req_ready) begin
               item_in  = req_data;
               rd_en    = 1'b1;
               state_in = S_UPDATE;
            end
         end
         S_UPDATE: begin
            if (out_free) begin
               state_in = S_READY;
               unique case (item_ff.cmd)
                  CMD_START_LOCAL, CMD_START_INTER: begin
                     phase_in    = (item_ff.cmd == CMD_START_LOCAL) ? PH_LOCAL : PH_INTER;
                     total_in    = 9'd0;
                     clr_addr_in = '0;
                     state_in    = S_CLEAR;
                  end
                  CMD_PACKET: begin
                     if (!in_range) begin
                        bad = 1'b1;
                     end else if (phase_ff == PH_LOCAL || phase_ff == PH_INTER) begin
                        wr_en   = 1'b1;
                        wr_addr = item_addr;
                        wr_data = {was_done || reach, new_cnt};
                        if (reach && !was_done) begin
                           became   = 1'b1;
                           total_in = total_inc;
                           if (total_inc >= active) begin
                              finished = 1'b1;
                              if (phase_ff == PH_INTER) begin
                                 phase_in = PH_DONE;
                              end
                           end
                        end
                     end
                  end
                  default: ;
               endcase
               rsp_valid_in                 = 1'b1;
               rsp_data_in.phase_now        = phase_in;
               rsp_data_in.rank_became_done = became;
               rsp_data_in.phase_finished   = finished;
               rsp_data_in.ranks_done       = total_in;
               rsp_data_in.bad_rank         = bad;
            end
         end
         default: state_in = S_CLEAR;
      endcase

      if (cfg_write || (phase_in != phase_ff)) begin
         settle_in = SettleCycles;
      end else if (settle_ff != 2'd0) begin
         settle_in = settle_ff - 2'd1;
      end else begin
         settle_in = settle_ff;
      end
   end

   // counter memory: bit COUNT_BITS is the rank done mark
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[AW'(req_data.dest_rank)];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff            <= S_CLEAR;
         phase_ff            <= PH_IDLE;
         total_ff            <= 9'd0;
         settle_ff           <= SettleCycles;
         clr_addr_ff         <= '0;
         rsp_valid_ff        <= 1'b0;
         cfg_ff.ranks_per_node <= RANKS_PER_NODE_RST;
         cfg_ff.node_count     <= NODE_COUNT_RST;
         cfg_ff.rank_count     <= RANK_COUNT_RST;
         cfg_ff.chunk_bytes    <= CHUNK_BYTES_RST;
      end else begin
         state_ff     <= state_in;
         phase_ff     <= phase_in;
         total_ff     <= total_in;
         settle_ff    <= settle_in;
         clr_addr_ff  <= clr_addr_in;
         rsp_valid_ff <= rsp_valid_in;
         cfg_ff       <= cfg_in;
      end
      item_ff     <= item_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

`default_nettype wire

// ===== src/tgct_expect.sv =====
// tgct_expect: three-stage multiplier pipeline for the expected byte count of a phase
// depends on tgct_pkg for the configuration struct and phase codes
`timescale 1ns / 1ps
`default_nettype none

module tgct_expect #(
   parameter int COUNT_BITS = tgct_pkg::COUNT_BITS_DEF
) (
   input  wire logic                  clock,
   input  wire tgct_pkg::cfg_type     cfg,
   input  wire tgct_pkg::phase_type   phase,
   output logic [COUNT_BITS-1:0]      expected
);
   import tgct_pkg::*;

   localparam logic [63:0] CntMax = {64{1'b1}} >> (64 - COUNT_BITS);

   logic [4:0]            factor1;
   logic [8:0]            factor2;
   logic [PROD1_BITS-1:0] prod1_ff;
   logic [8:0]            factor2_ff;
   logic [PROD_BITS-1:0]  prod_ff;
   logic [63:0]           prod_wide;
   logic [63:0]           clamped;
   logic [COUNT_BITS-1:0] expected_ff;

   always_comb begin
      if (phase == PH_LOCAL) begin
         factor1 = (cfg.ranks_per_node == 5'd0) ? 5'd0 : cfg.ranks_per_node - 5'd1;
         factor2 = 9'd1;
      end else begin
         factor1 = cfg.ranks_per_node;
         factor2 = (cfg.node_count == 9'd0) ? 9'd0 : cfg.node_count - 9'd1;
      end
      prod_wide = 64'(prod_ff);
      if (prod_wide == 64'd0) begin
         clamped = 64'd1;
      end else if (prod_wide > CntMax) begin
         clamped = CntMax;
      end else begin
         clamped = prod_wide;
      end
   end

   always_ff @(posedge clock) begin
      prod1_ff    <= PROD1_BITS'(cfg.chunk_bytes) * PROD1_BITS'(factor1);
      factor2_ff  <= factor2;
      prod_ff     <= PROD_BITS'(prod1_ff) * PROD_BITS'(factor2_ff);
      expected_ff <= COUNT_BITS'(clamped);
   end

   assign expected = expected_ff;

endmodule

`default_nettype wire

// ===== src/tgct_checker.sv =====
// tgct_checker: port-level assertions for the two-phase gather completion tracker
// depends on tgct_pkg; bound to the top level at the end of this file
`timescale 1ns / 1ps
`default_nettype none

module tgct_checker (
   input wire logic               clock,
   input wire logic               reset,
   input wire logic               req_valid,
   input wire logic               req_ready,
   input wire logic               rsp_valid,
   input wire logic               rsp_ready,
   input wire tgct_pkg::rsp_type  rsp_data
);
   import tgct_pkg::*;

   // a stalled result beat holds
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("result beat changed while stalled");

   // nothing is offered or taken right after reset
   assert property (@(posedge clock)
      reset |=> !rsp_valid && !req_ready)
      else $error("handshake active right after reset");

   // one request in flight: no accept in the cycle after an accept
   assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("request taken while previous still updating");

   // a completed rank implies a non-idle phase, a nonzero done count and no bad rank
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.rank_became_done |->
         rsp_data.ranks_done != 9'd0 && !rsp_data.bad_rank
         && (rsp_data.phase_now == PH_LOCAL || rsp_data.phase_now == PH_INTER
             || rsp_data.phase_now == PH_DONE))
      else $error("rank done flag with inconsistent result");

   // phase finish only on a completing beat
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.phase_finished |-> rsp_data.rank_became_done)
      else $error("phase finished without a rank completing");

endmodule

bind two_phase_gather_completion_tracker tgct_checker u_tgct_checker (
   .clock    (clock),
   .reset    (reset),
   .req_valid(req_valid),
   .req_ready(req_ready),
   .rsp_valid(rsp_valid),
   .rsp_ready(rsp_ready),
   .rsp_data (rsp_data)
);

`default_nettype wire
